// ----- hw/rtl/ppb_pkg.sv -----
// Shared types, codes and constant tables for the polar particle binning block.
package ppb_pkg;

  // Request codes
  localparam logic [1:0] REQ_BIN  = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_RCLR = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 4'd3;

  // CORDIC datapath widths (Q4.30 vectors, 2^32-per-turn angle)
  localparam int unsigned TRIG_W  = 34;
  localparam int unsigned ANGLE_W = 33;
  localparam int unsigned COORD_W = 20;
  localparam int unsigned IDX_W   = 22;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Bin update kind picked once the address is known
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INC,
    KIND_READ,
    KIND_CLR
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic rot;
    logic mul_coord;
    logic mul_idx;
    logic addr;
    logic rd;
    logic upd;
    logic clr;
  } ppb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic iter_last;
    logic clr_last;
    logic out_free;
  } ppb_sts_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic [31:0] ppb_atan(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/polar_particle_binning.sv -----
// Top level of the polar particle binning block.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per transfer:
//   bin a particle (radius, angle), read a bin, or read and clear a bin.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   request, in order: in-range flag, bin column, bin row and count.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i),
//   registers x_min, y_min, x_scale, y_scale at indexes 0 to 3.
// Sequencing:
//   A particle passes the rotation, coordinate multiply, index multiply, address,
//   memory read and update steps, using the single iterative CORDIC rotator (one
//   micro-rotation per cycle). A read request passes only the address, memory
//   read and update steps. The next request is taken once the update is done.
//   One request is in flight at a time.
// Reset:
//   After reset the histogram memory is swept to zero, one entry per cycle,
//   all NBINS_X * NBINS_Y entries, while in_stall_o stays high.
// Stall:
//   A result sits in the output register until taken; the next request is
//   already accepted and worked on, and waits only at its memory update.
module polar_particle_binning #(
  parameter int NBINS_X      = 64,
  parameter int NBINS_Y      = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [15:0]                   radius_i,
  input  logic [15:0]                   angle_i,
  input  logic [5:0]                    read_x_i,
  input  logic [5:0]                    read_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          in_range_o,
  output logic [5:0]                    bin_col_o,
  output logic [5:0]                    bin_row_o,
  output logic [31:0]                   bin_count_o
);
  import ppb_pkg::*;

  ppb_cmd_t cmd;
  ppb_sts_t sts;
  logic     req_bin;

  assign req_bin = (req_type_i == REQ_BIN);

  ppb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_bin_i  (req_bin),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  ppb_datapath #(
    .NBINS_X      (NBINS_X),
    .NBINS_Y      (NBINS_Y),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_type_i),
    .radius_i    (radius_i),
    .angle_i     (angle_i),
    .read_x_i    (read_x_i),
    .read_y_i    (read_y_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .in_range_o  (in_range_o),
    .bin_col_o   (bin_col_o),
    .bin_row_o   (bin_row_o),
    .bin_count_o (bin_count_o)
  );

`ifndef SYNTHESIS
  // an update always loads the output register
  a_upd_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd |=> out_valid_o)
    else $error("update did not present a result");

  // an update never overwrites a result still held by a stall
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

  // no request is taken during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> in_stall_o)
    else $error("request accepted during clear");
`endif

endmodule

// ----- hw/rtl/ppb_ctrl.sv -----
// Sequencing state machine for the polar particle binning block.
module ppb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              req_bin_i,
  input  ppb_pkg::ppb_sts_t sts_i,
  output logic              in_stall_o,
  output ppb_pkg::ppb_cmd_t cmd_o
);
  import ppb_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_ROT   = 4'd2;
  localparam logic [3:0] ST_MULC  = 4'd3;
  localparam logic [3:0] ST_MULI  = 4'd4;
  localparam logic [3:0] ST_ADDR  = 4'd5;
  localparam logic [3:0] ST_READ  = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;

  logic [3:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = req_bin_i ? ST_ROT : ST_ADDR;
        end
      end
      ST_ROT: begin
        cmd_o.rot = 1'b1;
        if (sts_i.iter_last) state_d = ST_MULC;
      end
      ST_MULC: begin
        cmd_o.mul_coord = 1'b1;
        state_d = ST_MULI;
      end
      ST_MULI: begin
        cmd_o.mul_idx = 1'b1;
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        // wait for the output register to be free
        if (sts_i.out_free) begin
          cmd_o.upd = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

endmodule

// ----- hw/rtl/ppb_datapath.sv -----
// CORDIC, binning arithmetic, histogram memory and output register.
module ppb_datapath #(
  parameter int NBINS_X      = 64,
  parameter int NBINS_Y      = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ppb_pkg::ppb_cmd_t               cmd_i,
  output ppb_pkg::ppb_sts_t               sts_o,
  input  logic                            cfg_we_i,
  input  logic [ppb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [15:0]                     cfg_wdata_i,
  input  logic [1:0]                      req_type_i,
  input  logic [15:0]                     radius_i,
  input  logic [15:0]                     angle_i,
  input  logic [5:0]                      read_x_i,
  input  logic [5:0]                      read_y_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic                            in_range_o,
  output logic [5:0]                      bin_col_o,
  output logic [5:0]                      bin_row_o,
  output logic [31:0]                     bin_count_o
);
  import ppb_pkg::*;

  localparam int CW    = $clog2(NBINS_X);
  localparam int RW    = $clog2(NBINS_Y);
  localparam int DEPTH = NBINS_X * NBINS_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(CORDIC_STEPS);

  // Configuration registers
  logic [15:0] x_min_q, y_min_q, x_scale_q, y_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q   <= 16'd0;
      y_min_q   <= 16'd0;
      x_scale_q <= 16'd256;
      y_scale_q <= 16'd256;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_X_MIN)   x_min_q   <= cfg_wdata_i;
      if (cfg_idx_i == CFG_Y_MIN)   y_min_q   <= cfg_wdata_i;
      if (cfg_idx_i == CFG_X_SCALE) x_scale_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_Y_SCALE) y_scale_q <= cfg_wdata_i;
    end
  end

  // Request latch
  logic [1:0]  req_q;
  logic [15:0] rad_q;
  logic [5:0]  rx_q, ry_q;
  logic        flip_q;
  logic        flip_d;
  logic [15:0] ang_sum;

  assign ang_sum = angle_i + 16'h4000;
  assign flip_d  = ang_sum[15];

  // CORDIC iteration registers
  logic signed [TRIG_W-1:0]  x_q, y_q, x_d, y_d, xs, ys;
  logic signed [ANGLE_W-1:0] z_q, z_d, atan_v;
  logic [IW-1:0]             iter_q;

  assign xs     = x_q >>> iter_q;
  assign ys     = y_q >>> iter_q;
  assign atan_v = $signed({1'b0, ppb_atan(5'(iter_q))});

  // one micro-rotation per cycle
  always_comb begin
    if (!z_q[ANGLE_W-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - atan_v;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + atan_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      rad_q  <= radius_i;
      rx_q   <= read_x_i;
      ry_q   <= read_y_i;
      flip_q <= flip_d;
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= $signed({angle_i[15] ^ flip_d, angle_i[15] ^ flip_d, angle_i[14:0], 16'd0});
      iter_q <= '0;
    end else if (cmd_i.rot) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      iter_q <= iter_q + 1'b1;
    end
  end

  assign sts_o.iter_last = (iter_q == IW'(CORDIC_STEPS - 1));

  // Coordinates: floor(radius * trig / 2^30)
  logic signed [TRIG_W-1:0]  cos_v, sin_v;
  logic signed [TRIG_W+16:0] prod_cx, prod_cy;
  logic signed [COORD_W-1:0] cx_q, cy_q;

  assign cos_v   = flip_q ? -x_q : x_q;
  assign sin_v   = flip_q ? -y_q : y_q;
  assign prod_cx = $signed({1'b0, rad_q}) * cos_v;
  assign prod_cy = $signed({1'b0, rad_q}) * sin_v;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_coord) begin
      cx_q <= prod_cx[COORD_W+29:30];
      cy_q <= prod_cy[COORD_W+29:30];
    end
  end

  // Bin indexes: floor((coord - min) * scale / 2^16)
  logic signed [COORD_W:0]    dx, dy;
  logic signed [COORD_W+17:0] prod_ix, prod_iy;
  logic signed [IDX_W-1:0]    ix_q, iy_q;

  assign dx      = {cx_q[COORD_W-1], cx_q} - (COORD_W+1)'($signed(x_min_q));
  assign dy      = {cy_q[COORD_W-1], cy_q} - (COORD_W+1)'($signed(y_min_q));
  assign prod_ix = dx * $signed({1'b0, x_scale_q});
  assign prod_iy = dy * $signed({1'b0, y_scale_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_idx) begin
      ix_q <= prod_ix[IDX_W+15:16];
      iy_q <= prod_iy[IDX_W+15:16];
    end
  end

  // Address, range check and update kind
  logic [AW-1:0] addr_q, addr_d;
  logic          ok_q, ok_d;
  logic [5:0]    col_q, col_d, row_q, row_d;
  kind_e         kind_q, kind_d;
  logic          okb, okr;

  assign okb = (ix_q >= 0) && (ix_q < NBINS_X) && (iy_q >= 0) && (iy_q < NBINS_Y);
  assign okr = (int'(rx_q) < NBINS_X) && (int'(ry_q) < NBINS_Y);

  always_comb begin
    addr_d = '0;
    ok_d   = 1'b0;
    col_d  = '0;
    row_d  = '0;
    kind_d = KIND_NONE;
    unique case (req_q)
      REQ_BIN: begin
        addr_d = AW'(ix_q[CW-1:0]) * AW'(NBINS_Y) + AW'(iy_q[RW-1:0]);
        if (okb) begin
          ok_d   = 1'b1;
          col_d  = ix_q[5:0];
          row_d  = iy_q[5:0];
          kind_d = KIND_INC;
        end
      end
      REQ_READ, REQ_RCLR: begin
        addr_d = AW'(rx_q) * AW'(NBINS_Y) + AW'(ry_q);
        col_d  = rx_q;
        row_d  = ry_q;
        if (okr) begin
          ok_d   = 1'b1;
          kind_d = (req_q == REQ_RCLR) ? KIND_CLR : KIND_READ;
        end
      end
      default: kind_d = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      addr_q <= addr_d;
      ok_q   <= ok_d;
      col_q  <= col_d;
      row_q  <= row_d;
      kind_q <= kind_d;
    end
  end

  // Histogram memory and clearing sweep
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_q;
  logic [31:0]   new_cnt;
  logic [31:0]   res_cnt;
  logic          wr_en;
  logic [AW-1:0] clr_q;

  assign new_cnt = (rdata_q == 32'hFFFF_FFFF) ? rdata_q : rdata_q + 32'd1;

  always_comb begin
    wr_en   = 1'b0;
    res_cnt = '0;
    unique case (kind_q)
      KIND_INC: begin
        wr_en   = 1'b1;
        res_cnt = new_cnt;
      end
      KIND_READ: res_cnt = rdata_q;
      KIND_CLR: begin
        wr_en   = 1'b1;
        res_cnt = rdata_q;
      end
      default: res_cnt = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem[clr_q] <= '0;
    end else if (cmd_i.upd && wr_en) begin
      mem[addr_q] <= (kind_q == KIND_INC) ? new_cnt : 32'd0;
    end
    if (cmd_i.rd) rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr) clr_q <= clr_q + 1'b1;
  end

  assign sts_o.clr_last = (clr_q == AW'(DEPTH - 1));

  // Output register
  logic        out_valid_q;
  logic        out_ok_q;
  logic [5:0]  out_col_q, out_row_q;
  logic [31:0] out_cnt_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.upd) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      out_ok_q  <= ok_q;
      out_col_q <= col_q;
      out_row_q <= row_q;
      out_cnt_q <= res_cnt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_range_o  = out_ok_q;
  assign bin_col_o   = out_col_q;
  assign bin_row_o   = out_row_q;
  assign bin_count_o = out_cnt_q;

endmodule

// ----- sim/polar_particle_binning_tb.sv -----
// Testbench for polar_particle_binning: directed and random requests checked against a histogram model.
`timescale 1ns / 100ps

module polar_particle_binning_tb;
  import ppb_pkg::*;

  localparam int NX = 64;
  localparam int NY = 64;
  localparam int STEPS = 16;
  localparam int SETTLE = STEPS + 16;
  localparam longint GAIN_Q30 = 652032874;

  typedef struct {
    logic [1:0]  req;
    logic [15:0] radius;
    logic [15:0] angle;
    logic [5:0]  rx;
    logic [5:0]  ry;
  } req_t;

  typedef struct {
    logic        in_range;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [31:0] count;
  } bin_res_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic in_valid_i, in_stall_o;
  logic [1:0] req_type_i;
  logic [15:0] radius_i, angle_i;
  logic [5:0] read_x_i, read_y_i;
  logic out_valid_o, out_stall_i;
  logic in_range_o;
  logic [5:0] bin_col_o, bin_row_o;
  logic [31:0] bin_count_o;

  // Model state
  logic [31:0] hist [NX*NY];
  logic [15:0] m_x_min, m_y_min, m_x_scale, m_y_scale;
  bin_res_t expected_bins[$];
  int errors = 0;
  bit calm = 0;
  int hold = 0;

  longint atan_tab [24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                            10679838, 5340245, 2670163, 1335087, 667544, 333772,
                            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
                            652, 326, 163, 81};

  polar_particle_binning i_dut (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("** polar_particle_binning: FAILED **");
    $finish;
  end

  // Rotation-mode CORDIC giving cos and sin in Q2.30
  function automatic void rotate(input logic [15:0] angle, output longint c, output longint s);
    logic [31:0] a;
    logic flip;
    longint x, y, z, xs, ys;
    a = {angle, 16'h0};
    flip = a[31] ^ a[30];
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint bin_of(logic [15:0] radius, longint trig, logic [15:0] lo,
                                    logic [15:0] scale);
    longint coord;
    coord = (longint'(radius) * trig) >>> 30;
    return ((coord - longint'($signed(lo))) * longint'(scale)) >>> 16;
  endfunction

  // Expected result of one request, with histogram update
  function automatic bin_res_t histogram_step(req_t r);
    bin_res_t e;
    longint c, s, ix, iy;
    int a;
    e = '{1'b0, 6'd0, 6'd0, 32'd0};
    if (r.req == REQ_BIN) begin
      rotate(r.angle, c, s);
      ix = bin_of(r.radius, c, m_x_min, m_x_scale);
      iy = bin_of(r.radius, s, m_y_min, m_y_scale);
      if (ix >= 0 && ix < NX && iy >= 0 && iy < NY) begin
        a = int'(ix) * NY + int'(iy);
        if (hist[a] != 32'hFFFF_FFFF) hist[a] = hist[a] + 1;
        e = '{1'b1, 6'(ix), 6'(iy), hist[a]};
      end
    end else if (r.req == REQ_READ || r.req == REQ_RCLR) begin
      a = int'(r.rx) * NY + int'(r.ry);
      e = '{1'b1, r.rx, r.ry, hist[a]};
      if (r.req == REQ_RCLR) hist[a] = '0;
    end
    return e;
  endfunction

  // One request transfer; valid stays high for a following send
  task automatic send(req_t r);
    in_valid_i <= 1'b1;
    req_type_i <= r.req;
    radius_i <= r.radius;
    angle_i <= r.angle;
    read_x_i <= r.rx;
    read_y_i <= r.ry;
    do @(posedge clk_i); while (in_stall_o);
    expected_bins.push_back(histogram_step(r));
  endtask

  task automatic pause(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) pause($urandom_range(1, 11));
  endtask

  // Wait for all results, then for the block to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_bins.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write enable stays high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_X_MIN:   m_x_min = v;
      CFG_Y_MIN:   m_y_min = v;
      CFG_X_SCALE: m_x_scale = v;
      CFG_Y_SCALE: m_y_scale = v;
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [15:0] xm, logic [15:0] ym, logic [15:0] xs, logic [15:0] ys);
    drain();
    write_reg(CFG_X_MIN, xm);
    write_reg(CFG_Y_MIN, ym);
    write_reg(CFG_X_SCALE, xs);
    write_reg(CFG_Y_SCALE, ys);
    cfg_we_i <= 1'b0;
  endtask

  function automatic req_t particle(logic [15:0] radius, logic [15:0] angle);
    return '{REQ_BIN, radius, angle, 6'($urandom), 6'($urandom)};
  endfunction

  function automatic req_t bin_read(logic [1:0] kind, logic [5:0] x, logic [5:0] y);
    return '{kind, 16'($urandom), 16'($urandom), x, y};
  endfunction

  function automatic req_t random_req(int near);
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r = particle(16'($urandom), 16'($urandom));
    if (pick < 70) begin
      if ($urandom_range(0, 9) != 0) r.radius = 16'($urandom_range(0, near));
    end else if (pick < 82) begin
      r.req = REQ_READ;
    end else if (pick < 96) begin
      r.req = REQ_RCLR;
    end else begin
      r.req = 2'd3;
    end
    return r;
  endfunction

  // Fresh histogram reads zero; unused request code
  task automatic test_reset_state();
    send(bin_read(REQ_READ, 6'd0, 6'd0));
    send(bin_read(REQ_READ, 6'd63, 6'd63));
    send(bin_read(REQ_RCLR, 6'd63, 6'd0));
    send(bin_read(2'd3, 6'd5, 6'd7));
  endtask

  // Axis angles, wrap angle, radius extremes, repeated hits and clear
  task automatic test_directed_particles();
    send(particle(16'd0, 16'd0));
    send(particle(16'd0, 16'd0));
    send(particle(16'h0A00, 16'd0));
    send(particle(16'h0A00, 16'd16384));
    send(particle(16'h0A00, 16'd32768));
    send(particle(16'h0A00, 16'd49152));
    send(particle(16'h0A00, 16'd65535));
    send(particle(16'h1400, 16'd8192));
    send(particle(16'h1400, 16'd8192));
    send(particle(16'hFFFF, 16'd8192));
    send(particle(16'hFFFF, 16'd40000));
    send(bin_read(REQ_READ, 6'd0, 6'd0));
    send(bin_read(REQ_RCLR, 6'd0, 6'd0));
    send(bin_read(REQ_READ, 6'd0, 6'd0));
  endtask

  // Extreme register values
  task automatic test_grid_extremes();
    set_grid(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    send(particle(16'h0100, 16'd0));
    send(particle(16'hFFFF, 16'd32768));
    set_grid(16'h7FFF, 16'h7FFF, 16'd0, 16'd0);
    send(particle(16'h0100, 16'd0));
    send(particle(16'hFFFF, 16'd16384));
    set_grid(16'd0, 16'd0, 16'd0, 16'd0);
    send(particle(16'h0100, 16'd30000));
  endtask

  task automatic test_random(int n, int near);
    for (int i = 0; i < n; i++) begin
      maybe_gap();
      send(random_req(near));
    end
  endtask

  // Receiver stall bursts
  always @(posedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      hold--;
      if (hold == 0) out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      hold = $urandom_range(1, 11);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    bin_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bins.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_bins.pop_front();
        if (in_range_o !== e.in_range) begin
          $error("in_range: expected %0d, actual %0d", e.in_range, in_range_o);
          errors++;
        end
        if (bin_col_o !== e.col) begin
          $error("bin_col: expected %0d, actual %0d", e.col, bin_col_o);
          errors++;
        end
        if (bin_row_o !== e.row) begin
          $error("bin_row: expected %0d, actual %0d", e.row, bin_row_o);
          errors++;
        end
        if (bin_count_o !== e.count) begin
          $error("bin_count: expected %0d, actual %0d", e.count, bin_count_o);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    req_type_i = '0;
    radius_i = '0;
    angle_i = '0;
    read_x_i = '0;
    read_y_i = '0;
    out_stall_i = 1'b0;
    foreach (hist[i]) hist[i] = '0;
    m_x_min = 16'd0;
    m_y_min = 16'd0;
    m_x_scale = 16'd256;
    m_y_scale = 16'd256;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait out the clearing sweep
    do @(posedge clk_i); while (in_stall_o);

    test_reset_state();
    test_directed_particles();
    test_grid_extremes();
    // Default grid, first quadrant
    set_grid(16'd0, 16'd0, 16'd256, 16'd256);
    test_random(150, 16'h3000);
    // Centered grid, one bin per 256 units
    set_grid(-16'sd8192, -16'sd8192, 16'd256, 16'd256);
    test_random(200, 16'h2400);
    // Grid over negative x and y, fine bins
    set_grid(-16'sd4096, -16'sd2048, 16'd1024, 16'd2048);
    test_random(200, 16'h1000);
    // Coarse bins, no idling
    set_grid(-16'sd32768, -16'sd32768, 16'd64, 16'd80);
    calm = 1;
    test_random(200, 16'hFFFF);

    drain();
    if (errors == 0) $display("** polar_particle_binning: PASSED **");
    else $display("** polar_particle_binning: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ppb_pkg.sv
hw/rtl/ppb_ctrl.sv
hw/rtl/ppb_datapath.sv
hw/rtl/polar_particle_binning.sv
sim/polar_particle_binning_tb.sv
